>>> sv/rpt_pkg.sv
// ----------------------------------------------------------------------------
// rpt_pkg
// Shared constants and types for the range increment / point query tree.
// ----------------------------------------------------------------------------
package rpt_pkg;

    localparam int LEAVES      = 1024;
    localparam int COUNT_WIDTH = 32;
    localparam int IDX_W       = 10;
    localparam int CFG_W       = 11;
    localparam int ACT_W       = 2;
    localparam int NODE_AW     = $clog2(2 * LEAVES);
    localparam int NODES       = 2 * LEAVES;
    localparam int CUR_W       = NODE_AW + 1;

    typedef enum logic [ACT_W-1:0] {
        ACT_CLEAR = 2'd0,
        ACT_ADD   = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

endpackage

>>> sv/rpt_if.sv
// ----------------------------------------------------------------------------
// rpt_req_if / rpt_rsp_if
// Valid/ready channels for items and results of the tree.
// ----------------------------------------------------------------------------
interface rpt_req_if
    import rpt_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [ACT_W-1:0] action;
    logic [IDX_W-1:0] range_low;
    logic [IDX_W-1:0] range_high;
    logic [IDX_W-1:0] query_index;

    modport source (output valid, action, range_low, range_high, query_index, input ready);
    modport sink   (input valid, action, range_low, range_high, query_index, output ready);
endinterface

interface rpt_rsp_if
    import rpt_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [COUNT_WIDTH-1:0] leaf_count;

    modport source (output valid, leaf_count, input ready);
    modport sink   (input valid, leaf_count, output ready);
endinterface

>>> sv/rpt_ram.sv
// ----------------------------------------------------------------------------
// rpt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rpt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/range_increment_point_query_tree.sv
// ----------------------------------------------------------------------------
// range_increment_point_query_tree
// Segment tree of saturating leaf counters: clear, range add, point query.
// ----------------------------------------------------------------------------
// The tree keeps one 32-bit add counter per node in a 2048-entry RAM (leaves
// at nodes 1024..2047). A range add walks the range bottom-up and does a
// read-modify-write on each covering node, with a step for each level
// shift: at most about 20 nodes and ten shifts. A point query for an index
// in use reads the 11 nodes on the leaf-to-root path back to back and sums
// them with saturation; an index beyond the last leaf in use returns zero.
// Clear, a cfg_we write and reset each run a clearing pass over all 2048
// RAM entries, one entry a cycle, while no item is accepted. One item
// is worked on at a time; a finished result waits in an output register.
module range_increment_point_query_tree
    import rpt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_data,
    rpt_req_if.sink          req,
    rpt_rsp_if.source        rsp
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CLEAR  = 6'b000010,
        S_SCAN   = 6'b000100,
        S_ADD_WR = 6'b001000,
        S_WALK   = 6'b010000,
        S_QEND   = 6'b100000
    } state_t;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       last_reg, last_next;
    logic [NODE_AW-1:0]     clr_reg, clr_next;
    logic [CUR_W-1:0]       l_reg, l_next, r_reg, r_next;
    logic [NODE_AW-1:0]     tgt_reg, tgt_next;
    logic [NODE_AW-1:0]     node_reg, node_next;
    logic [COUNT_WIDTH-1:0] acc_reg, acc_next;
    logic                   accv_reg, accv_next;
    logic                   ov_reg, ov_next;
    logic [COUNT_WIDTH-1:0] oc_reg, oc_next;

    logic                   we;
    logic [NODE_AW-1:0]     waddr, raddr;
    logic [COUNT_WIDTH-1:0] wdata, rdata;
    logic [COUNT_WIDTH:0]   sum;
    logic [COUNT_WIDTH-1:0] sum_sat, inc_sat;
    logic [IDX_W-1:0]       hi_clip;
    logic [IDX_W-1:0]       cfg_last;

    rpt_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NODES)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // saturating arithmetic on the read data, range clipping and config decode
    always_comb
    begin
        sum     = {1'b0, acc_reg} + {1'b0, (accv_reg ? rdata : '0)};
        sum_sat = sum[COUNT_WIDTH] ? COUNT_MAX : sum[COUNT_WIDTH-1:0];
        inc_sat = (rdata == COUNT_MAX) ? COUNT_MAX : rdata + 1'b1;
        hi_clip = (req.range_high > last_reg) ? last_reg : req.range_high;
        if (cfg_data == '0)
        begin
            cfg_last = '0;
        end
        else if (cfg_data > CFG_W'(LEAVES))
        begin
            cfg_last = IDX_W'(LEAVES - 1);
        end
        else
        begin
            cfg_last = IDX_W'(cfg_data - 1'b1);
        end
    end

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = ov_reg;
    assign rsp.leaf_count = oc_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        clr_next   = clr_reg;
        l_next     = l_reg;
        r_next     = r_reg;
        tgt_next   = tgt_reg;
        node_next  = node_reg;
        acc_next   = acc_reg;
        accv_next  = accv_reg;
        ov_next    = ov_reg && !rsp.ready;
        oc_next    = oc_reg;
        we         = 1'b0;
        waddr      = tgt_reg;
        wdata      = inc_sat;
        raddr      = node_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    case (action_t'(req.action))
                        ACT_CLEAR:
                        begin
                            clr_next   = '0;
                            state_next = S_CLEAR;
                        end
                        ACT_ADD:
                        begin
                            if (req.range_low <= hi_clip)
                            begin
                                l_next = CUR_W'(LEAVES) + CUR_W'(req.range_low);
                                r_next = CUR_W'(LEAVES) + CUR_W'(hi_clip) + 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                        ACT_QUERY:
                        begin
                            acc_next  = '0;
                            accv_next = 1'b0;
                            node_next = NODE_AW'(LEAVES) + NODE_AW'(req.query_index);
                            state_next = (req.query_index <= last_reg) ? S_WALK : S_QEND;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                we    = 1'b1;
                waddr = clr_reg;
                wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == NODE_AW'(NODES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (l_reg >= r_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (l_reg[0])
                begin
                    raddr      = l_reg[NODE_AW-1:0];
                    tgt_next   = l_reg[NODE_AW-1:0];
                    l_next     = l_reg + 1'b1;
                    state_next = S_ADD_WR;
                end
                else if (r_reg[0])
                begin
                    raddr      = NODE_AW'(r_reg - 1'b1);
                    tgt_next   = NODE_AW'(r_reg - 1'b1);
                    r_next     = r_reg - 1'b1;
                    state_next = S_ADD_WR;
                end
                else
                begin
                    l_next = l_reg >> 1;
                    r_next = r_reg >> 1;
                end
            end
            S_ADD_WR:
            begin
                we         = 1'b1;
                state_next = S_SCAN;
            end
            S_WALK:
            begin
                acc_next  = sum_sat;
                accv_next = 1'b1;
                if (node_reg == NODE_AW'(1))
                begin
                    state_next = S_QEND;
                end
                else
                begin
                    node_next = node_reg >> 1;
                end
            end
            S_QEND:
            begin
                if (!ov_reg || rsp.ready)
                begin
                    ov_next    = 1'b1;
                    oc_next    = sum_sat;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // a register write restarts the tree empty
        if (cfg_we)
        begin
            last_next  = cfg_last;
            clr_next   = '0;
            state_next = S_CLEAR;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            last_reg  <= IDX_W'(LEAVES - 1);
            clr_reg   <= '0;
            accv_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
            clr_reg   <= clr_next;
            accv_reg  <= accv_next;
            ov_reg    <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        l_reg    <= l_next;
        r_reg    <= r_next;
        tgt_reg  <= tgt_next;
        node_reg <= node_next;
        acc_reg  <= acc_next;
        oc_reg   <= oc_next;
    end

`ifndef NO_ASSERTIONS
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !req.ready)
        else $error("item taken during clearing pass");

    a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ov_reg) |-> $past(state_reg == S_QEND))
        else $error("result raised outside query end");

    a_add_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADD_WR) |-> $past(state_reg == S_SCAN))
        else $error("counter write without its read");
`endif

endmodule
